// ----- sv/iotp_pkg.sv -----
// Shared types, constants and helper functions of the offset table parser.
package iotp_pkg;

    localparam int SIGNATURE_COUNT = 6;
    localparam int SIG_TABLE       = 6;
    localparam int SIG_USED        = (SIGNATURE_COUNT < SIG_TABLE) ? SIGNATURE_COUNT : SIG_TABLE;
    localparam int SIG_LEN         = 12;
    localparam int MAX_FIELDS      = 8;
    localparam int POS_MAX         = 63;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        KIND_NONE    = 4'd0,
        KIND_TOTAL   = 4'd1,
        KIND_EXE_OFF = 4'd2,
        KIND_EXE_CMP = 4'd3,
        KIND_EXE_UNC = 4'd4,
        KIND_EXE_CRC = 4'd5,
        KIND_ADLER   = 4'd6,
        KIND_MSG     = 4'd7,
        KIND_HDR     = 4'd8,
        KIND_DATA    = 4'd9,
        KIND_REV     = 4'd10,
        KIND_CHK     = 4'd11
    } kind_t;

    typedef enum logic [2:0] {
        ST_PENDING = 3'd0,
        ST_OK      = 3'd1,
        ST_BAD_SIG = 3'd2,
        ST_BAD_REV = 3'd3,
        ST_TRUNC   = 3'd4,
        ST_BAD_CRC = 3'd5
    } status_t;

    // one queued word, already sorted into restart / end / byte
    typedef struct packed {
        logic       restart;
        logic       ended;
        logic [7:0] data;
    } iotp_item_t;

    localparam logic [7:0] SIG_BYTES [SIG_TABLE][SIG_LEN] = '{
        '{8'h72, 8'h44, 8'h6c, 8'h50, 8'h74, 8'h53, 8'h30, 8'h32, 8'h87, 8'h65, 8'h56, 8'h78},
        '{8'h72, 8'h44, 8'h6c, 8'h50, 8'h74, 8'h53, 8'h30, 8'h34, 8'h87, 8'h65, 8'h56, 8'h78},
        '{8'h72, 8'h44, 8'h6c, 8'h50, 8'h74, 8'h53, 8'h30, 8'h35, 8'h87, 8'h65, 8'h56, 8'h78},
        '{8'h72, 8'h44, 8'h6c, 8'h50, 8'h74, 8'h53, 8'h30, 8'h36, 8'h87, 8'h65, 8'h56, 8'h78},
        '{8'h72, 8'h44, 8'h6c, 8'h50, 8'h74, 8'h53, 8'h30, 8'h37, 8'h87, 8'h65, 8'h56, 8'h78},
        '{8'h72, 8'h44, 8'h6c, 8'h50, 8'h74, 8'h53, 8'hcd, 8'he6, 8'hd7, 8'h7b, 8'h0b, 8'h2a}
    };

    // field order per version; row 0 and row 7 are never used
    localparam kind_t SEQ_KIND [8][MAX_FIELDS] = '{
        '{KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE,
          KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE},
        '{KIND_TOTAL, KIND_EXE_OFF, KIND_EXE_CMP, KIND_EXE_UNC,
          KIND_ADLER, KIND_MSG, KIND_HDR, KIND_DATA},
        '{KIND_TOTAL, KIND_EXE_OFF, KIND_EXE_CMP, KIND_EXE_UNC,
          KIND_ADLER, KIND_HDR, KIND_DATA, KIND_NONE},
        '{KIND_TOTAL, KIND_EXE_OFF, KIND_EXE_CMP, KIND_EXE_UNC,
          KIND_EXE_CRC, KIND_HDR, KIND_DATA, KIND_NONE},
        '{KIND_TOTAL, KIND_EXE_OFF, KIND_EXE_CMP, KIND_EXE_UNC,
          KIND_EXE_CRC, KIND_HDR, KIND_DATA, KIND_CHK},
        '{KIND_TOTAL, KIND_EXE_OFF, KIND_EXE_UNC, KIND_EXE_CRC,
          KIND_HDR, KIND_DATA, KIND_CHK, KIND_NONE},
        '{KIND_REV, KIND_TOTAL, KIND_EXE_OFF, KIND_EXE_UNC,
          KIND_EXE_CRC, KIND_HDR, KIND_DATA, KIND_CHK},
        '{KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE,
          KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE}
    };

    localparam logic [3:0] SEQ_LEN [8] = '{4'd0, 4'd8, 4'd7, 4'd7, 4'd8, 4'd7, 4'd8, 4'd0};

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ----- sv/iotp_front.sv -----
// Input side: takes words, sorts them into queue entries, holds a short queue.
module iotp_front
    import iotp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       table_start,
    input  logic       stream_ended,
    input  logic       data_valid,
    output logic       data_ready,
    output iotp_item_t q_item,
    output logic       q_valid,
    input  logic       q_pop
);

    iotp_item_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg;
    logic [QCNT_W-1:0]     count_next;
    logic                  push;
    logic                  pop;
    iotp_item_t            item_in;

    assign data_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = data_valid && data_ready;
    assign q_valid    = (count_reg != '0);
    assign pop        = q_pop && q_valid;
    assign q_item     = entry_reg[rd_ptr_reg];

    // an end marker carries no byte
    always_comb
    begin
        item_in.restart = table_start;
        item_in.ended   = stream_ended;
        item_in.data    = stream_ended ? 8'd0 : data_byte;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ----- sv/iotp_back.sv -----
// Parser core: signature match, field assembly, CRC and result register.
module iotp_back
    import iotp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  iotp_item_t  q_item,
    input  logic        q_valid,
    output logic        q_ready,
    output logic [3:0]  field_kind,
    output logic [31:0] field_value,
    output logic [2:0]  version_code,
    output logic        done_res,
    output logic [2:0]  status,
    output logic        result_valid,
    input  logic        result_ready
);

    logic [5:0]                 pos_reg, pos_next;
    logic [SIGNATURE_COUNT-1:0] match_reg, match_next;
    logic [2:0]                 ver_reg, ver_next;
    logic [31:0]                crc_reg, crc_next;
    logic [23:0]                wb_reg, wb_next;
    logic [3:0]                 step_reg, step_next;
    logic                       fin_reg, fin_next;

    logic                       out_valid_reg, out_valid_next;
    kind_t                      out_kind_reg, res_kind;
    logic [31:0]                out_value_reg, res_value;
    logic [2:0]                 out_ver_reg;
    logic                       out_done_reg, res_done;
    status_t                    out_status_reg, res_status;
    logic                       res_hit;

    logic                       pop;
    kind_t                      kind;
    logic [5:0]                 rel_pos;
    logic [31:0]                word;

    assign q_ready = !out_valid_reg || result_ready;
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        pos_next   = pos_reg;
        match_next = match_reg;
        ver_next   = ver_reg;
        crc_next   = crc_reg;
        wb_next    = wb_reg;
        step_next  = step_reg;
        fin_next   = fin_reg;
        res_hit    = 1'b0;
        res_kind   = KIND_NONE;
        res_value  = '0;
        res_status = ST_PENDING;
        res_done   = 1'b0;
        kind       = SEQ_KIND[ver_reg][step_reg[2:0]];
        rel_pos    = pos_reg - 6'(SIG_LEN);
        word       = {q_item.data, wb_reg};

        if (pop)
        begin
            if (q_item.restart)
            begin
                pos_next   = '0;
                match_next = '1;
                ver_next   = '0;
                crc_next   = CRC_INIT;
                wb_next    = '0;
                step_next  = '0;
                fin_next   = 1'b0;
            end

            if (q_item.ended)
            begin
                if (!fin_next)
                begin
                    res_hit    = 1'b1;
                    res_status = ST_TRUNC;
                    res_done   = 1'b1;
                end
            end
            else if (!fin_next)
            begin
                if (pos_next < 6'(SIG_LEN))
                begin
                    crc_next = crc_byte(crc_next, q_item.data);
                    for (int i = 0; i < SIG_USED; i++)
                    begin
                        if (SIG_BYTES[i][pos_next[3:0]] != q_item.data)
                        begin
                            match_next[i] = 1'b0;
                        end
                    end
                    if (pos_next == 6'(SIG_LEN - 1))
                    begin
                        // lowest matching signature wins
                        for (int i = SIG_USED - 1; i >= 0; i--)
                        begin
                            if (match_next[i])
                            begin
                                ver_next = 3'(i + 1);
                            end
                        end
                        if (ver_next == '0)
                        begin
                            res_hit    = 1'b1;
                            res_status = ST_BAD_SIG;
                            res_done   = 1'b1;
                        end
                    end
                    pos_next = pos_next + 1'b1;
                end
                else if (ver_reg == '0 || ver_reg > 3'd6 || step_reg >= SEQ_LEN[ver_reg])
                begin
                    res_hit    = 1'b1;
                    res_status = ST_TRUNC;
                    res_done   = 1'b1;
                end
                else
                begin
                    if (kind != KIND_MSG && kind != KIND_CHK)
                    begin
                        crc_next = crc_byte(crc_reg, q_item.data);
                    end
                    if (pos_reg < 6'(POS_MAX))
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    case (rel_pos[1:0])
                        2'd0:    wb_next = {wb_reg[23:8], q_item.data};
                        2'd1:    wb_next = {wb_reg[23:16], q_item.data, wb_reg[7:0]};
                        2'd2:    wb_next = {q_item.data, wb_reg[15:0]};
                        default:
                        begin
                            wb_next   = '0;
                            step_next = step_reg + 1'b1;
                            if (kind == KIND_REV)
                            begin
                                if (word != 32'd1)
                                begin
                                    res_hit    = 1'b1;
                                    res_value  = word;
                                    res_status = ST_BAD_REV;
                                    res_done   = 1'b1;
                                end
                            end
                            else if (kind == KIND_CHK)
                            begin
                                res_hit    = 1'b1;
                                res_value  = word;
                                res_status = ((crc_reg ^ CRC_INIT) == word) ? ST_OK : ST_BAD_CRC;
                                res_done   = 1'b1;
                            end
                            else
                            begin
                                res_hit   = 1'b1;
                                res_kind  = kind;
                                res_value = word;
                                if (step_next >= SEQ_LEN[ver_reg])
                                begin
                                    res_status = ST_OK;
                                    res_done   = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end

            if (res_done)
            begin
                fin_next = 1'b1;
            end
        end

        out_valid_next = pop ? res_hit : (out_valid_reg && !result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            match_reg     <= '1;
            ver_reg       <= '0;
            crc_reg       <= CRC_INIT;
            wb_reg        <= '0;
            step_reg      <= '0;
            fin_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            match_reg     <= match_next;
            ver_reg       <= ver_next;
            crc_reg       <= crc_next;
            wb_reg        <= wb_next;
            step_reg      <= step_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && res_hit)
        begin
            out_kind_reg   <= res_kind;
            out_value_reg  <= res_value;
            out_ver_reg    <= ver_next;
            out_done_reg   <= res_done;
            out_status_reg <= res_status;
        end
    end

    assign result_valid = out_valid_reg;
    assign field_kind   = out_kind_reg;
    assign field_value  = out_value_reg;
    assign version_code = out_ver_reg;
    assign done_res     = out_done_reg;
    assign status       = out_status_reg;

endmodule

// ----- sv/installer_offset_table_parser.sv -----
// Top level of the offset table parser: input queue plus parser core.
// Throughput: one byte word per cycle, sustained, when results are taken.
// Path: a taken byte is held in the two-entry input queue, then the parser
//   handles it and writes any result into its result register.
// Reset: queue empty, no result pending, parser idle; bytes are ignored
//   until a word with table_start set arrives.
module installer_offset_table_parser
    import iotp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // byte channel
    input  logic [7:0]  data_byte,
    input  logic        table_start,
    input  logic        stream_ended,
    input  logic        data_valid,
    output logic        data_ready,
    // result channel
    output logic [3:0]  field_kind,
    output logic [31:0] field_value,
    output logic [2:0]  version_code,
    output logic        done_res,
    output logic [2:0]  status,
    output logic        result_valid,
    input  logic        result_ready
);

    iotp_item_t q_item;
    logic       q_valid;
    logic       q_ready;

    // Front: takes a word whenever the queue has room. At full rate one entry
    // is in use, so the spare entry takes one more word while a result sits
    // unclaimed; after that the byte side is held off until the queue has room.
    iotp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .table_start  (table_start),
        .stream_ended (stream_ended),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_pop        (q_ready)
    );

    // Back: one queue entry per cycle while the result register is free or
    // being drained; signature match, word assembly and byte CRC all fit in
    // that cycle.
    iotp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .field_kind   (field_kind),
        .field_value  (field_value),
        .version_code (version_code),
        .done_res     (done_res),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // a final word always carries a verdict
    a_done_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && done_res |-> status != ST_PENDING)
        else $error("final result without status");

    // intermediate words are real fields, still pending
    a_mid_is_field: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !done_res |-> status == ST_PENDING && field_kind != KIND_NONE)
        else $error("intermediate result malformed");

    // no version can be known when the signature did not match
    a_bad_sig_no_ver: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_BAD_SIG |-> version_code == 3'd0 && done_res)
        else $error("unknown signature with version set");

endmodule

// ----- tb/sv/tb.sv -----
// Testbench of the offset table parser: random table streams checked against a local parser.
module tb;
    import iotp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_WORDS  = 1150;   // words that belong to tables (ignored noise not counted)
    localparam int RUN_LIMIT    = 200000; // cycles; the run is stopped as a mismatch at this count
    localparam int HOLD_CYCLES  = 300;    // long result stall, forces the input side to back up
    localparam int HOLD_AFTER   = 300;    // words taken before the long stall begins
    localparam int DRAIN_CYCLES = 20;     // quiet cycles after the last expected result

    // pacing of each side: no gaps, short gaps, or the full 0..14 range
    typedef enum int {PACE_FULL, PACE_LIGHT, PACE_RANDOM} pace_t;

    // how a generated table is spoiled, if at all
    typedef enum int {CLEAN, BREAK_SIG, BREAK_REV, BREAK_CRC, BREAK_END, BREAK_RESTART} fault_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       ended;
    } byte_word_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic [2:0]  ver;
        logic        done;
        status_t     st;
    } table_result_t;

    // signature bytes of versions 1..6
    localparam logic [7:0] SIG_PATTERN [6][12] = '{
        '{8'h72, 8'h44, 8'h6c, 8'h50, 8'h74, 8'h53, 8'h30, 8'h32, 8'h87, 8'h65, 8'h56, 8'h78},
        '{8'h72, 8'h44, 8'h6c, 8'h50, 8'h74, 8'h53, 8'h30, 8'h34, 8'h87, 8'h65, 8'h56, 8'h78},
        '{8'h72, 8'h44, 8'h6c, 8'h50, 8'h74, 8'h53, 8'h30, 8'h35, 8'h87, 8'h65, 8'h56, 8'h78},
        '{8'h72, 8'h44, 8'h6c, 8'h50, 8'h74, 8'h53, 8'h30, 8'h36, 8'h87, 8'h65, 8'h56, 8'h78},
        '{8'h72, 8'h44, 8'h6c, 8'h50, 8'h74, 8'h53, 8'h30, 8'h37, 8'h87, 8'h65, 8'h56, 8'h78},
        '{8'h72, 8'h44, 8'h6c, 8'h50, 8'h74, 8'h53, 8'hcd, 8'he6, 8'hd7, 8'h7b, 8'h0b, 8'h2a}
    };

    // word order of each version; row 0 is never selected
    localparam kind_t FIELD_ORDER [7][8] = '{
        '{KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE,
          KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE},
        '{KIND_TOTAL, KIND_EXE_OFF, KIND_EXE_CMP, KIND_EXE_UNC,
          KIND_ADLER, KIND_MSG, KIND_HDR, KIND_DATA},
        '{KIND_TOTAL, KIND_EXE_OFF, KIND_EXE_CMP, KIND_EXE_UNC,
          KIND_ADLER, KIND_HDR, KIND_DATA, KIND_NONE},
        '{KIND_TOTAL, KIND_EXE_OFF, KIND_EXE_CMP, KIND_EXE_UNC,
          KIND_EXE_CRC, KIND_HDR, KIND_DATA, KIND_NONE},
        '{KIND_TOTAL, KIND_EXE_OFF, KIND_EXE_CMP, KIND_EXE_UNC,
          KIND_EXE_CRC, KIND_HDR, KIND_DATA, KIND_CHK},
        '{KIND_TOTAL, KIND_EXE_OFF, KIND_EXE_UNC, KIND_EXE_CRC,
          KIND_HDR, KIND_DATA, KIND_CHK, KIND_NONE},
        '{KIND_REV, KIND_TOTAL, KIND_EXE_OFF, KIND_EXE_UNC,
          KIND_EXE_CRC, KIND_HDR, KIND_DATA, KIND_CHK}
    };
    localparam int FIELD_COUNT [7] = '{0, 8, 7, 7, 8, 7, 8};

    // DUT ports; every input known from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  data_byte = 8'd0;
    logic        table_start = 1'b0;
    logic        stream_ended = 1'b0;
    logic        data_valid = 1'b0;
    logic        data_ready;
    logic [3:0]  field_kind;
    logic [31:0] field_value;
    logic [2:0]  version_code;
    logic        done_res;
    logic [2:0]  status;
    logic        result_valid;
    logic        result_ready = 1'b0;

    // local parser state, mirrors the block after reset (idle until a table start)
    logic [5:0]  parse_pos = 6'd0;
    logic [5:0]  parse_sig = 6'h3f;
    logic [2:0]  parse_ver = 3'd0;
    logic [31:0] parse_crc = 32'hffff_ffff;
    logic [23:0] parse_acc = 24'd0;
    logic [3:0]  parse_step = 4'd0;
    logic        parse_idle = 1'b1;

    byte_word_t    table_bytes_q [$];   // words not yet taken by the block
    table_result_t expected_fields [$]; // predicted results, oldest first

    int    table_words = 0;
    int    words_taken = 0;
    int    cycles = 0;
    int    mismatches = 0;
    logic  word_taken = 1'b0;   // set at the rising edge, read by the drivers at the falling edge
    logic  result_taken = 1'b0;
    logic  hold_results = 1'b0;

    installer_offset_table_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .table_start  (table_start),
        .stream_ended (stream_ended),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .field_kind   (field_kind),
        .field_value  (field_value),
        .version_code (version_code),
        .done_res     (done_res),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // reflected CRC-32, LSB first, one byte at a time
    function automatic logic [31:0] crc32_shift(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int n = 0; n < 8; n++)
        begin
            if (c[0])
                c = (c >> 1) ^ 32'hedb8_8320;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // builds a result; a done result puts the parser back to idle
    function automatic table_result_t field_out(input kind_t k, input logic [31:0] v,
                                                input status_t s, input logic last);
        table_result_t r;
        r.kind  = k;
        r.value = v;
        r.ver   = parse_ver;
        r.done  = last;
        r.st    = s;
        if (last)
            parse_idle = 1'b1;
        return r;
    endfunction

    // advances the local parser by one taken word; returns 1 when a result is due
    function automatic logic parse_byte(input byte_word_t w, output table_result_t r);
        kind_t       k;
        logic [1:0]  lane;
        logic [31:0] word;
        r = '0;
        if (w.start)
        begin
            parse_pos  = 6'd0;
            parse_sig  = 6'h3f;
            parse_ver  = 3'd0;
            parse_crc  = 32'hffff_ffff;
            parse_acc  = 24'd0;
            parse_step = 4'd0;
            parse_idle = 1'b0;
        end
        // end of stream never carries a byte; only reported while a table is open
        if (w.ended)
        begin
            if (parse_idle)
                return 1'b0;
            r = field_out(KIND_NONE, 32'd0, ST_TRUNC, 1'b1);
            return 1'b1;
        end
        if (parse_idle)
            return 1'b0;

        // signature: every candidate still alive is compared, lowest index wins
        if (parse_pos < 6'd12)
        begin
            parse_crc = crc32_shift(parse_crc, w.data);
            for (int i = 0; i < 6; i++)
            begin
                if (SIG_PATTERN[i][parse_pos] != w.data)
                    parse_sig[i] = 1'b0;
            end
            parse_pos++;
            if (parse_pos == 6'd12)
            begin
                for (int i = 5; i >= 0; i--)
                begin
                    if (parse_sig[i])
                        parse_ver = 3'(i + 1);
                end
                if (parse_ver == 3'd0)
                begin
                    r = field_out(KIND_NONE, 32'd0, ST_BAD_SIG, 1'b1);
                    return 1'b1;
                end
            end
            return 1'b0;
        end

        // field words, little endian; message and check words stay out of the CRC
        k = FIELD_ORDER[parse_ver][parse_step];
        if (k != KIND_MSG && k != KIND_CHK)
            parse_crc = crc32_shift(parse_crc, w.data);
        lane = 2'(parse_pos - 6'd12);
        if (parse_pos != 6'd63)
            parse_pos++;
        if (lane != 2'd3)
        begin
            parse_acc[8*lane +: 8] = w.data;
            return 1'b0;
        end
        word = {w.data, parse_acc};
        parse_acc = 24'd0;
        parse_step++;

        if (k == KIND_REV)
        begin
            if (word == 32'd1)
                return 1'b0;
            r = field_out(KIND_NONE, word, ST_BAD_REV, 1'b1);
            return 1'b1;
        end
        if (k == KIND_CHK)
            r = field_out(KIND_NONE, word, (~parse_crc == word) ? ST_OK : ST_BAD_CRC, 1'b1);
        else if (parse_step >= 4'(FIELD_COUNT[parse_ver]))
            r = field_out(k, word, ST_OK, 1'b1);
        else
            r = field_out(k, word, ST_PENDING, 1'b0);
        return 1'b1;
    endfunction

    function automatic int draw_gap(input pace_t pace);
        case (pace)
            PACE_FULL:  return 0;
            PACE_LIGHT: return $urandom_range(0, 2);
            default:    return $urandom_range(0, 14);
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_word(input logic [7:0] d, input logic s, input logic e);
        byte_word_t w;
        w.data  = d;
        w.start = s;
        w.ended = e;
        table_bytes_q.push_back(w);
    endfunction

    // one table image of the given version, spoiled as the fault asks
    task automatic queue_table(input int ver, input fault_t fault);
        logic [7:0]  img [$];
        logic [31:0] crc;
        logic [31:0] value;
        int          spot;
        int          cut;
        kind_t       k;
        crc = 32'hffff_ffff;
        for (int i = 0; i < 12; i++)
            img.push_back(SIG_PATTERN[ver-1][i]);

        if (fault == BREAK_SIG)
        begin
            // mostly a flipped byte; now and then the near miss "03" that no version uses
            if ($urandom_range(0, 3) == 0)
                img[7] = 8'h33;
            else
            begin
                spot = $urandom_range(0, 11);
                img[spot] = img[spot] ^ 8'($urandom_range(1, 255));
            end
        end
        else
        begin
            foreach (img[i])
                crc = crc32_shift(crc, img[i]);
            for (int f = 0; f < FIELD_COUNT[ver]; f++)
            begin
                k = FIELD_ORDER[ver][f];
                case (k)
                    KIND_REV:
                    begin
                        value = 32'd1;
                        if (fault == BREAK_REV)
                        begin
                            do
                                value = rand_word();
                            while (value == 32'd1);
                        end
                    end
                    KIND_CHK:
                    begin
                        value = ~crc;
                        if (fault == BREAK_CRC)
                            value = value ^ (32'd1 << $urandom_range(0, 31));
                    end
                    default: value = rand_word();
                endcase
                for (int b = 0; b < 4; b++)
                begin
                    img.push_back(value[8*b +: 8]);
                    if (k != KIND_MSG && k != KIND_CHK)
                        crc = crc32_shift(crc, value[8*b +: 8]);
                end
            end
        end

        cut = img.size();
        if (fault == BREAK_END || fault == BREAK_RESTART)
            cut = $urandom_range(1, img.size() - 1);
        for (int i = 0; i < cut; i++)
            push_word(img[i], i == 0, 1'b0);
        if (fault == BREAK_END)
            push_word(8'($urandom), 1'b0, 1'b1);
        table_words += cut;
    endtask

    task automatic note_failure(input string what);
        if (mismatches < 10)
            $display("%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // byte side: a fresh wait is drawn for every word once the previous one is taken
    always @(negedge clk)
    begin : byte_driver
        static int    tx_gap = 0;
        static int    tx_count = 0;
        static pace_t tx_pace = PACE_RANDOM;
        if (rst_n && (word_taken || !data_valid))
        begin
            if (word_taken)
            begin
                tx_count++;
                if (tx_count % 64 == 0)
                    tx_pace = pace_t'($urandom_range(0, 2));
                tx_gap = draw_gap(tx_pace);
            end
            if (tx_gap != 0)
            begin
                tx_gap--;
                data_valid <= 1'b0;
            end
            else if (table_bytes_q.size() != 0)
            begin
                data_byte    <= table_bytes_q[0].data;
                table_start  <= table_bytes_q[0].start;
                stream_ended <= table_bytes_q[0].ended;
                data_valid   <= 1'b1;
            end
            else
                data_valid <= 1'b0;
        end
    end

    // result side: a stall drawn after every taken result; the long hold overrides it
    always @(negedge clk)
    begin : result_pacer
        static int    rx_stall = 0;
        static int    rx_count = 0;
        static pace_t rx_pace = PACE_RANDOM;
        if (rst_n)
        begin
            if (result_taken)
            begin
                rx_count++;
                if (rx_count % 40 == 0)
                    rx_pace = pace_t'($urandom_range(0, 2));
                rx_stall = draw_gap(rx_pace);
            end
            else if (rx_stall != 0)
                rx_stall--;
            result_ready <= (rx_stall == 0) && !hold_results;
        end
    end

    // predicts on every taken word, checks every taken result against the oldest prediction
    always @(posedge clk)
    begin : monitor
        byte_word_t    w;
        table_result_t pred;
        table_result_t got;
        word_taken   = 1'b0;
        result_taken = 1'b0;
        cycles++;
        if (rst_n)
        begin
            if (data_valid && data_ready)
            begin
                w = table_bytes_q.pop_front();
                if (parse_byte(w, pred))
                    expected_fields.push_back(pred);
                word_taken = 1'b1;
                words_taken++;
            end
            if (result_valid && result_ready)
            begin
                result_taken = 1'b1;
                got.kind  = kind_t'(field_kind);
                got.value = field_value;
                got.ver   = version_code;
                got.done  = done_res;
                got.st    = status_t'(status);
                if (expected_fields.size() == 0)
                    note_failure($sformatf("unexpected result kind %0d value %h status %0d",
                                           field_kind, field_value, status));
                else
                begin
                    pred = expected_fields.pop_front();
                    if (got !== pred)
                        note_failure($sformatf(
                            "kind %0d/%0d value %h/%h ver %0d/%0d done %0d/%0d status %0d/%0d",
                            pred.kind, got.kind, pred.value, got.value, pred.ver, got.ver,
                            pred.done, got.done, pred.st, got.st));
                end
            end
        end
    end

    // long receiver stall while the sender keeps offering words
    initial
    begin
        wait (words_taken >= HOLD_AFTER);
        @(posedge clk);
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
    end

    initial
    begin
        wait (cycles >= RUN_LIMIT);
        $display("installer_offset_table_parser: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int pick;
        int ver;

        // idle: bytes and an end of stream with no table open give nothing
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hff, 1'b0, 1'b0);
        push_word(8'h5a, 1'b0, 1'b1);
        // table start together with end of stream: truncated at once, no version
        push_word(8'hff, 1'b1, 1'b1);
        // all-ones signature matches nothing
        for (int i = 0; i < 12; i++)
            push_word(8'hff, i == 0, 1'b0);
        // end of stream inside the signature
        push_word(8'h72, 1'b1, 1'b0);
        push_word(8'h44, 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b1);

        // random part: mostly well-formed tables, the rest spoiled or noise
        while (table_words < TABLE_WORDS)
        begin
            pick = $urandom_range(0, 99);
            ver  = $urandom_range(1, 6);
            if (pick < 58)
                queue_table(ver, CLEAN);
            else if (pick < 66)
                queue_table($urandom_range(4, 6), BREAK_CRC);
            else if (pick < 72)
                queue_table(6, BREAK_REV);
            else if (pick < 80)
                queue_table(ver, BREAK_END);
            else if (pick < 86)
                queue_table(ver, BREAK_SIG);
            else if (pick < 91)
                queue_table(ver, BREAK_RESTART);
            else if (pick < 94)
            begin
                push_word(8'($urandom), 1'b1, 1'b1);
                table_words++;
            end
            else
            begin
                // stray words between tables
                repeat ($urandom_range(1, 3))
                    push_word(8'($urandom), 1'b0, $urandom_range(0, 3) == 0);
            end
        end

        // reset: held low, released away from the rising edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (table_bytes_q.size() != 0 || expected_fields.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("installer_offset_table_parser: match");
        else
            $display("installer_offset_table_parser: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/iotp_pkg.sv
sv/iotp_front.sv
sv/iotp_back.sv
sv/installer_offset_table_parser.sv
tb/sv/tb.sv
